// ===== src/next_fit_block_allocator_macros.svh =====
// assertion macros shared by the allocator rtl
`ifndef NEXT_FIT_BLOCK_ALLOCATOR_MACROS_SVH
`define NEXT_FIT_BLOCK_ALLOCATOR_MACROS_SVH

`ifndef SYNTHESIS
`define NFBA_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle implication failed");
`define NFBA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle implication failed");
`else
`define NFBA_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define NFBA_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

// ===== src/nfba_pkg.sv =====
// shared types, constants and helpers of the next-fit block allocator
package nfba_pkg;

   localparam int MAX_BLOCKS = 32;
   localparam int SIZE_BITS  = 16;
   localparam int IDX_W      = $clog2(MAX_BLOCKS);
   localparam int CNT_W      = $clog2(MAX_BLOCKS + 1);
   localparam int CSR_W      = 6;
   localparam int SPAN_RESET = 32;
   localparam int SLOT_W     = 5;
   localparam int FIELD_W    = 16;
   localparam int INT_W      = 32;
   localparam int EXT_W      = 21;
   localparam int EXT_MAX    = MAX_BLOCKS * ((2 ** SIZE_BITS) - 1);

   localparam logic CMD_LOAD  = 1'b0;
   localparam logic CMD_ALLOC = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOAD,
      ST_SCAN,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic                 rd_en;
      logic [IDX_W-1:0]     rd_addr;
      logic                 wr_en;
      logic [IDX_W-1:0]     wr_addr;
      logic [SIZE_BITS-1:0] wr_data;
   } store_req_type;

   function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] idx,
                                                 input logic [CNT_W-1:0] span);
      logic [CNT_W-1:0] inc;
      inc = CNT_W'(idx) + CNT_W'(1);
      return (inc == span) ? '0 : inc[IDX_W-1:0];
   endfunction

endpackage

// ===== src/nfba_store.sv =====
// free-size table: synchronous ram with per-entry valid bits cleared at reset
module nfba_store (
   input  logic                           clock,
   input  logic                           reset,
   input  nfba_pkg::store_req_type        store_req,
   output logic [nfba_pkg::SIZE_BITS-1:0] rd_data
);

   logic [nfba_pkg::SIZE_BITS-1:0]  mem [nfba_pkg::MAX_BLOCKS];
   logic [nfba_pkg::MAX_BLOCKS-1:0] valid_ff;
   logic [nfba_pkg::SIZE_BITS-1:0]  rd_data_ff;
   logic                            rd_vld_ff;

   always_ff @(posedge clock) begin
      if (store_req.wr_en) begin
         mem[store_req.wr_addr] <= store_req.wr_data;
      end
      if (store_req.rd_en) begin
         rd_data_ff <= mem[store_req.rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         if (store_req.wr_en) begin
            valid_ff[store_req.wr_addr] <= 1'b1;
         end
         if (store_req.rd_en) begin
            rd_vld_ff <= valid_ff[store_req.rd_addr];
         end
      end
   end

   assign rd_data = rd_vld_ff ? rd_data_ff : '0;

endmodule

// ===== src/next_fit_block_allocator.sv =====
// Next-fit block allocator. A load item writes one entry of the free-size table, clears the
// scan pointer and the internal-fragmentation total. An allocate item scans circularly from
// the pointer, reading one table entry per cycle through the single read port of the table
// ram; it examines at most the clamped span set by the csr, so at most 32 entries. One item
// is in work at a time; a finished result sits in the output register, so the next item may
// be taken while it waits. The table reads as zero after reset with no clearing pass.
`include "next_fit_block_allocator_macros.svh"

module next_fit_block_allocator (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_wr_en,
   input  logic [nfba_pkg::CSR_W-1:0]     csr_wr_data,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic                           req_command,
   input  logic [nfba_pkg::SLOT_W-1:0]    req_block_slot,
   input  logic [nfba_pkg::FIELD_W-1:0]   req_block_size,
   input  logic [nfba_pkg::FIELD_W-1:0]   req_request_size,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic                           rsp_granted,
   output logic [nfba_pkg::SLOT_W-1:0]    rsp_chosen_block,
   output logic [nfba_pkg::FIELD_W-1:0]   rsp_size_before,
   output logic [nfba_pkg::FIELD_W-1:0]   rsp_leftover,
   output logic [nfba_pkg::INT_W-1:0]     rsp_internal_total,
   output logic [nfba_pkg::EXT_W-1:0]     rsp_external_total
);

   nfba_pkg::state_type state_ff, state_in;

   logic [nfba_pkg::CSR_W-1:0]     bus_ff;
   logic [nfba_pkg::IDX_W-1:0]     ptr_ff, ptr_in;
   logic [nfba_pkg::INT_W-1:0]     int_sum_ff, int_sum_in;
   logic [nfba_pkg::EXT_W-1:0]     free_sum_ff, free_sum_in;
   logic                           rsp_valid_ff, rsp_valid_in;

   logic                           cmd_ff, cmd_in;
   logic [nfba_pkg::SLOT_W-1:0]    slot_ff, slot_in;
   logic [nfba_pkg::SIZE_BITS-1:0] size_ff, size_in;
   logic [nfba_pkg::SIZE_BITS-1:0] reqsz_ff, reqsz_in;
   logic [nfba_pkg::IDX_W-1:0]     start_ff, start_in;
   logic [nfba_pkg::IDX_W-1:0]     iss_ptr_ff, iss_ptr_in;
   logic [nfba_pkg::IDX_W-1:0]     chk_ptr_ff, chk_ptr_in;
   logic [nfba_pkg::CNT_W-1:0]     chk_cnt_ff, chk_cnt_in;
   logic [nfba_pkg::CNT_W-1:0]     span_ff, span_in;
   logic                           hit_ff, hit_in;
   logic [nfba_pkg::SIZE_BITS-1:0] before_ff, before_in;

   logic                           rsp_granted_ff, rsp_granted_in;
   logic [nfba_pkg::SLOT_W-1:0]    rsp_block_ff, rsp_block_in;
   logic [nfba_pkg::FIELD_W-1:0]   rsp_before_ff, rsp_before_in;
   logic [nfba_pkg::FIELD_W-1:0]   rsp_left_ff, rsp_left_in;
   logic [nfba_pkg::INT_W-1:0]     rsp_int_ff, rsp_int_in;
   logic [nfba_pkg::EXT_W-1:0]     rsp_ext_ff, rsp_ext_in;

   nfba_pkg::store_req_type        store_req;
   logic [nfba_pkg::SIZE_BITS-1:0] rd_data;

   logic [nfba_pkg::CNT_W-1:0]     span_now;
   logic [nfba_pkg::IDX_W-1:0]     start_now;
   logic                           slot_ok;
   logic [nfba_pkg::SIZE_BITS-1:0] after;
   logic [nfba_pkg::INT_W:0]       int_wide;

   nfba_store u_store (
      .clock     (clock),
      .reset     (reset),
      .store_req (store_req),
      .rd_data   (rd_data)
   );

   // clamp of the scan span to 1..MAX_BLOCKS
   always_comb begin
      if (bus_ff == '0) begin
         span_now = nfba_pkg::CNT_W'(1);
      end else if (32'(bus_ff) > 32'(nfba_pkg::MAX_BLOCKS)) begin
         span_now = nfba_pkg::CNT_W'(nfba_pkg::MAX_BLOCKS);
      end else begin
         span_now = nfba_pkg::CNT_W'(bus_ff);
      end
      start_now = (nfba_pkg::CNT_W'(ptr_ff) >= span_now) ? '0 : ptr_ff;
   end

   assign slot_ok  = 32'(slot_ff) < 32'(nfba_pkg::MAX_BLOCKS);
   assign after    = before_ff - reqsz_ff;
   assign int_wide = {1'b0, int_sum_ff} + (nfba_pkg::INT_W + 1)'(after);

   always_comb begin
      state_in       = state_ff;
      ptr_in         = ptr_ff;
      int_sum_in     = int_sum_ff;
      free_sum_in    = free_sum_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      cmd_in         = cmd_ff;
      slot_in        = slot_ff;
      size_in        = size_ff;
      reqsz_in       = reqsz_ff;
      start_in       = start_ff;
      iss_ptr_in     = iss_ptr_ff;
      chk_ptr_in     = chk_ptr_ff;
      chk_cnt_in     = chk_cnt_ff;
      span_in        = span_ff;
      hit_in         = hit_ff;
      before_in      = before_ff;
      rsp_granted_in = rsp_granted_ff;
      rsp_block_in   = rsp_block_ff;
      rsp_before_in  = rsp_before_ff;
      rsp_left_in    = rsp_left_ff;
      rsp_int_in     = rsp_int_ff;
      rsp_ext_in     = rsp_ext_ff;
      store_req      = '0;
      req_stall      = 1'b1;

      unique case (state_ff)
         nfba_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd_in   = req_command;
               slot_in  = req_block_slot;
               size_in  = nfba_pkg::SIZE_BITS'(req_block_size);
               reqsz_in = nfba_pkg::SIZE_BITS'(req_request_size);
               store_req.rd_en = 1'b1;
               if (req_command == nfba_pkg::CMD_LOAD) begin
                  store_req.rd_addr = nfba_pkg::IDX_W'(req_block_slot);
                  state_in          = nfba_pkg::ST_LOAD;
               end else begin
                  store_req.rd_addr = start_now;
                  start_in          = start_now;
                  chk_ptr_in        = start_now;
                  iss_ptr_in        = nfba_pkg::next_idx(start_now, span_now);
                  chk_cnt_in        = '0;
                  span_in           = span_now;
                  state_in          = nfba_pkg::ST_SCAN;
               end
            end
         end
         nfba_pkg::ST_LOAD: begin
            before_in = slot_ok ? rd_data : '0;
            hit_in    = 1'b0;
            state_in  = nfba_pkg::ST_DONE;
         end
         nfba_pkg::ST_SCAN: begin
            if (rd_data >= reqsz_ff) begin
               hit_in    = 1'b1;
               before_in = rd_data;
               state_in  = nfba_pkg::ST_DONE;
            end else if (chk_cnt_ff + nfba_pkg::CNT_W'(1) == span_ff) begin
               hit_in   = 1'b0;
               state_in = nfba_pkg::ST_DONE;
            end else begin
               store_req.rd_en   = 1'b1;
               store_req.rd_addr = iss_ptr_ff;
               chk_ptr_in        = iss_ptr_ff;
               iss_ptr_in        = nfba_pkg::next_idx(iss_ptr_ff, span_ff);
               chk_cnt_in        = chk_cnt_ff + nfba_pkg::CNT_W'(1);
            end
         end
         nfba_pkg::ST_DONE: begin
            if (!(rsp_valid_ff && rsp_stall)) begin
               rsp_valid_in = 1'b1;
               state_in     = nfba_pkg::ST_IDLE;
               if (cmd_ff == nfba_pkg::CMD_LOAD) begin
                  if (slot_ok) begin
                     store_req.wr_en   = 1'b1;
                     store_req.wr_addr = nfba_pkg::IDX_W'(slot_ff);
                     store_req.wr_data = size_ff;
                     free_sum_in = free_sum_ff - nfba_pkg::EXT_W'(before_ff)
                                   + nfba_pkg::EXT_W'(size_ff);
                  end
                  ptr_in         = '0;
                  int_sum_in     = '0;
                  rsp_granted_in = 1'b0;
                  rsp_block_in   = slot_ff;
                  rsp_before_in  = nfba_pkg::FIELD_W'(before_ff);
                  rsp_left_in    = slot_ok ? nfba_pkg::FIELD_W'(size_ff) : '0;
                  rsp_int_in     = '0;
                  rsp_ext_in     = free_sum_in;
               end else if (hit_ff) begin
                  store_req.wr_en   = 1'b1;
                  store_req.wr_addr = chk_ptr_ff;
                  store_req.wr_data = after;
                  free_sum_in    = free_sum_ff - nfba_pkg::EXT_W'(reqsz_ff);
                  ptr_in         = chk_ptr_ff;
                  int_sum_in     = int_wide[nfba_pkg::INT_W] ? '1
                                   : int_wide[nfba_pkg::INT_W-1:0];
                  rsp_granted_in = 1'b1;
                  rsp_block_in   = nfba_pkg::SLOT_W'(chk_ptr_ff);
                  rsp_before_in  = nfba_pkg::FIELD_W'(before_ff);
                  rsp_left_in    = nfba_pkg::FIELD_W'(after);
                  rsp_int_in     = int_sum_in;
                  rsp_ext_in     = free_sum_in;
               end else begin
                  ptr_in         = start_ff;
                  rsp_granted_in = 1'b0;
                  rsp_block_in   = '0;
                  rsp_before_in  = '0;
                  rsp_left_in    = '0;
                  rsp_int_in     = int_sum_ff;
                  rsp_ext_in     = free_sum_ff;
               end
            end
         end
         default: begin
            state_in = nfba_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= nfba_pkg::ST_IDLE;
         bus_ff       <= nfba_pkg::CSR_W'(nfba_pkg::SPAN_RESET);
         ptr_ff       <= '0;
         int_sum_ff   <= '0;
         free_sum_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ptr_ff       <= ptr_in;
         int_sum_ff   <= int_sum_in;
         free_sum_ff  <= free_sum_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            bus_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff         <= cmd_in;
      slot_ff        <= slot_in;
      size_ff        <= size_in;
      reqsz_ff       <= reqsz_in;
      start_ff       <= start_in;
      iss_ptr_ff     <= iss_ptr_in;
      chk_ptr_ff     <= chk_ptr_in;
      chk_cnt_ff     <= chk_cnt_in;
      span_ff        <= span_in;
      hit_ff         <= hit_in;
      before_ff      <= before_in;
      rsp_granted_ff <= rsp_granted_in;
      rsp_block_ff   <= rsp_block_in;
      rsp_before_ff  <= rsp_before_in;
      rsp_left_ff    <= rsp_left_in;
      rsp_int_ff     <= rsp_int_in;
      rsp_ext_ff     <= rsp_ext_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_granted        = rsp_granted_ff;
   assign rsp_chosen_block   = rsp_block_ff;
   assign rsp_size_before    = rsp_before_ff;
   assign rsp_leftover       = rsp_left_ff;
   assign rsp_internal_total = rsp_int_ff;
   assign rsp_external_total = rsp_ext_ff;

   `NFBA_ASSERT_NEXT(a_accept_leaves_idle, clock, reset, req_valid && !req_stall, state_ff != nfba_pkg::ST_IDLE)
   `NFBA_ASSERT_IMPLY(a_scan_count_in_span, clock, reset, state_ff == nfba_pkg::ST_SCAN, chk_cnt_ff < span_ff)
   `NFBA_ASSERT_IMPLY(a_grant_shrinks, clock, reset, rsp_valid_ff && rsp_granted_ff, rsp_left_ff <= rsp_before_ff)
   `NFBA_ASSERT_IMPLY(a_free_sum_bound, clock, reset, 1'b1, free_sum_ff <= nfba_pkg::EXT_W'(nfba_pkg::EXT_MAX))

endmodule

// ===== tb/tb.sv =====
// self-checking testbench for the next-fit block allocator
`timescale 1ns / 1ps

module tb;

   localparam int MAX_BLOCKS = nfba_pkg::MAX_BLOCKS;
   localparam int IDX_W = nfba_pkg::IDX_W;
   localparam int CSR_W = nfba_pkg::CSR_W;
   localparam int SLOT_W = nfba_pkg::SLOT_W;
   localparam int FIELD_W = nfba_pkg::FIELD_W;
   localparam int INT_W = nfba_pkg::INT_W;
   localparam int EXT_W = nfba_pkg::EXT_W;
   localparam logic CMD_LOAD = nfba_pkg::CMD_LOAD;
   localparam logic CMD_ALLOC = nfba_pkg::CMD_ALLOC;

   localparam int CYCLE_LIMIT = 200000;
   localparam int SETTLE_CYCLES = 40;
   localparam int HOLD_CYCLES = 300;
   localparam int PHASE_ITEMS = 28;
   localparam int FINAL_ITEMS = 16;

   typedef struct {
      logic               command;
      logic [SLOT_W-1:0]  slot;
      logic [FIELD_W-1:0] block_size;
      logic [FIELD_W-1:0] request_size;
   } alloc_req_type;

   typedef struct {
      logic               granted;
      logic [SLOT_W-1:0]  chosen;
      logic [FIELD_W-1:0] size_prior;
      logic [FIELD_W-1:0] leftover;
      logic [INT_W-1:0]   frag_total;
      logic [EXT_W-1:0]   free_total;
   } alloc_rsp_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_wr_en = 1'b0;
   logic [CSR_W-1:0] csr_wr_data = '0;
   logic req_valid = 1'b0;
   logic req_stall;
   logic req_command = CMD_LOAD;
   logic [SLOT_W-1:0] req_block_slot = '0;
   logic [FIELD_W-1:0] req_block_size = '0;
   logic [FIELD_W-1:0] req_request_size = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic rsp_granted;
   logic [SLOT_W-1:0] rsp_chosen_block;
   logic [FIELD_W-1:0] rsp_size_before;
   logic [FIELD_W-1:0] rsp_leftover;
   logic [INT_W-1:0] rsp_internal_total;
   logic [EXT_W-1:0] rsp_external_total;

   alloc_req_type pending_reqs[$];
   alloc_rsp_type expected_rsps[$];

   // predicted allocator state
   logic [FIELD_W-1:0] free_tab [MAX_BLOCKS];
   logic [IDX_W-1:0] scan_ptr;
   logic [INT_W-1:0] frag_sum;
   logic [EXT_W:0] free_sum;
   logic [CSR_W-1:0] span_cfg;

   int planned_size [MAX_BLOCKS];
   int mismatch_count = 0;
   int cycle_count = 0;
   int send_gap = 0;
   int stall_left = 0;
   int hold_left = 0;
   logic hold_start = 1'b0;
   logic calm = 1'b0;
   logic req_taken = 1'b0;

   next_fit_block_allocator DUT (
      .clock              (clock),
      .reset              (reset),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_command        (req_command),
      .req_block_slot     (req_block_slot),
      .req_block_size     (req_block_size),
      .req_request_size   (req_request_size),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_granted        (rsp_granted),
      .rsp_chosen_block   (rsp_chosen_block),
      .rsp_size_before    (rsp_size_before),
      .rsp_leftover       (rsp_leftover),
      .rsp_internal_total (rsp_internal_total),
      .rsp_external_total (rsp_external_total)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("next_fit_block_allocator verification failed");
         $finish;
      end
   end

   task automatic report_error(input string msg);
      $display("ERROR at cycle %0d: %s", cycle_count, msg);
      mismatch_count++;
   endtask

   task automatic check_field(input string name, input logic [63:0] got,
                              input logic [63:0] want);
      if (got !== want)
         report_error($sformatf("%s got %0d want %0d", name, got, want));
   endtask

   function automatic alloc_rsp_type predict_alloc(input alloc_req_type it);
      alloc_rsp_type r;
      int span;
      int p;
      int k;
      logic [INT_W:0] acc;
      r = '{default: '0};
      if (it.command == CMD_LOAD) begin
         r.size_prior = free_tab[it.slot];
         free_sum = free_sum - free_tab[it.slot] + it.block_size;
         free_tab[it.slot] = it.block_size;
         r.leftover = it.block_size;
         r.chosen = it.slot;
         scan_ptr = '0;
         frag_sum = '0;
      end else begin
         span = (span_cfg == 0) ? 1 : ((span_cfg > MAX_BLOCKS) ? MAX_BLOCKS : span_cfg);
         p = (scan_ptr >= span) ? 0 : scan_ptr;
         for (k = 0; k < span && !r.granted; k++) begin
            if (free_tab[p] >= it.request_size) r.granted = 1'b1;
            else p = (p + 1) % span;
         end
         scan_ptr = p[IDX_W-1:0];
         if (r.granted) begin
            r.size_prior = free_tab[p];
            r.leftover = free_tab[p] - it.request_size;
            free_tab[p] = r.leftover;
            free_sum = free_sum - it.request_size;
            r.chosen = p[SLOT_W-1:0];
            acc = {1'b0, frag_sum} + r.leftover;
            frag_sum = acc[INT_W] ? '1 : acc[INT_W-1:0];
         end
      end
      r.frag_total = frag_sum;
      r.free_total = free_sum[EXT_W-1:0];
      return r;
   endfunction

   function automatic int idle_len();
      int r;
      r = $urandom_range(0, 99);
      if (calm || r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(4, 30);
   endfunction

   // driver
   always @(negedge clock) begin
      alloc_req_type nxt;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (send_gap > 0) begin
            send_gap--;
            req_valid <= 1'b0;
         end else if (pending_reqs.size() != 0) begin
            nxt = pending_reqs.pop_front();
            req_command <= nxt.command;
            req_block_slot <= nxt.slot;
            req_block_size <= nxt.block_size;
            req_request_size <= nxt.request_size;
            req_valid <= 1'b1;
            send_gap = idle_len();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver stall
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_stall <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
         if (!calm && $urandom_range(0, 3) == 0) stall_left = idle_len();
      end
   end

   // long receiver hold-off
   always @(posedge clock) begin
      if (hold_start) hold_left <= HOLD_CYCLES;
      else if (hold_left > 0) hold_left <= hold_left - 1;
   end

   // monitor
   always @(posedge clock) begin
      alloc_req_type seen;
      alloc_rsp_type want;
      if (reset) begin
         for (int i = 0; i < MAX_BLOCKS; i++) free_tab[i] = '0;
         scan_ptr = '0;
         frag_sum = '0;
         free_sum = '0;
         span_cfg = CSR_W'(nfba_pkg::SPAN_RESET);
         req_taken <= 1'b0;
      end else begin
         if (csr_wr_en) span_cfg = csr_wr_data;
         req_taken <= req_valid && !req_stall;
         if (req_valid && !req_stall) begin
            seen.command = req_command;
            seen.slot = req_block_slot;
            seen.block_size = req_block_size;
            seen.request_size = req_request_size;
            expected_rsps.push_back(predict_alloc(seen));
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_rsps.size() == 0) begin
               report_error("result with nothing expected");
            end else begin
               want = expected_rsps.pop_front();
               check_field("granted", rsp_granted, want.granted);
               check_field("chosen_block", rsp_chosen_block, want.chosen);
               check_field("size_before", rsp_size_before, want.size_prior);
               check_field("leftover", rsp_leftover, want.leftover);
               check_field("internal_total", rsp_internal_total, want.frag_total);
               check_field("external_total", rsp_external_total, want.free_total);
            end
         end
      end
   end

   task automatic push_load(input int slot, input int size);
      alloc_req_type it;
      it.command = CMD_LOAD;
      it.slot = slot[SLOT_W-1:0];
      it.block_size = size[FIELD_W-1:0];
      it.request_size = FIELD_W'($urandom_range(0, 65535));
      planned_size[slot] = size;
      pending_reqs.push_back(it);
   endtask

   task automatic push_alloc(input int req);
      alloc_req_type it;
      it.command = CMD_ALLOC;
      it.slot = SLOT_W'($urandom_range(0, MAX_BLOCKS - 1));
      it.block_size = FIELD_W'($urandom_range(0, 65535));
      it.request_size = req[FIELD_W-1:0];
      pending_reqs.push_back(it);
   endtask

   task automatic wait_idle();
      @(negedge clock);
      #1;
      while (pending_reqs.size() != 0 || req_valid || expected_rsps.size() != 0) begin
         @(negedge clock);
         #1;
      end
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_span(input int value);
      wait_idle();
      csr_wr_en <= 1'b1;
      csr_wr_data <= value[CSR_W-1:0];
      @(negedge clock);
      csr_wr_en <= 1'b0;
      #1;
   endtask

   function automatic int pick_size();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) return 0;
      if (r == 1) return 65535;
      if (r < 5) return $urandom_range(0, 65535);
      return $urandom_range(100, 5000);
   endfunction

   function automatic int pick_request(input int span);
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) return 0;
      if (r == 1) return 65535;
      if (r < 4) return $urandom_range(0, 65535);
      if (r < 7) return $urandom_range(0, planned_size[$urandom_range(0, span - 1)]);
      return $urandom_range(1, 600);
   endfunction

   task automatic random_traffic(input int count, input int span);
      int made;
      int n;
      int slot;
      made = 0;
      while (made < count) begin
         if ($urandom_range(0, 5) == 0) begin
            for (int s = 0; s < MAX_BLOCKS; s++) push_load(s, pick_size());
            made += MAX_BLOCKS;
         end else begin
            n = $urandom_range(1, 4);
            repeat (n) begin
               slot = ($urandom_range(0, 4) == 0) ? $urandom_range(0, MAX_BLOCKS - 1)
                                                  : $urandom_range(0, span - 1);
               push_load(slot, pick_size());
            end
            made += n;
         end
         n = $urandom_range(3, 14);
         repeat (n) push_alloc(pick_request(span));
         made += n;
      end
   endtask

   initial begin
      int spans [10];
      int eff;
      spans = '{32, 1, 2, 17, 31, 0, 63, 40, 5, 0};
      spans[9] = $urandom_range(0, 63);
      for (int i = 0; i < MAX_BLOCKS; i++) planned_size[i] = 0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // empty table after reset, full span
      push_alloc(0);
      push_alloc(1);
      push_alloc(65535);
      push_load(31, 65535);
      push_load(0, 0);
      push_load(5, 100);
      push_load(10, 16'hAAAA);
      push_load(21, 16'h5555);
      push_alloc(65535);
      push_alloc(0);
      push_alloc(100);
      push_alloc(16'h5555);
      push_alloc(65535);
      push_alloc(1);
      // span of zero acts as one, pointer beyond span
      write_span(0);
      push_alloc(1);
      push_load(0, 65535);
      push_alloc(65535);
      push_alloc(0);
      // oversize span clamps, then shrink below the pointer
      write_span(63);
      push_load(20, 1000);
      push_alloc(16'h5555);
      write_span(8);
      push_alloc(0);
      push_alloc(1);

      for (int ph = 0; ph < 10; ph++) begin
         write_span(spans[ph]);
         eff = (spans[ph] == 0) ? 1 : ((spans[ph] > MAX_BLOCKS) ? MAX_BLOCKS : spans[ph]);
         calm <= (ph == 2);
         random_traffic(PHASE_ITEMS, eff);
         if (ph == 3) begin
            @(negedge clock);
            hold_start <= 1'b1;
            @(negedge clock);
            hold_start <= 1'b0;
         end
      end

      write_span(32);
      random_traffic(FINAL_ITEMS, MAX_BLOCKS);
      wait_idle();

      if (mismatch_count == 0) begin
         $display("next_fit_block_allocator verification clean");
      end else begin
         $display("next_fit_block_allocator verification failed");
      end
      $finish;
   end

endmodule
